/* hw/rtl/srsw_pkg.sv */
// ----------------------------------------------------------------------------
// srsw_pkg
// Shared types and constants for the selective-repeat sender window.
// ----------------------------------------------------------------------------
`default_nettype none

package srsw_pkg;

  localparam int WINDOW_MAX = 32;
  localparam int MAX_FRAMES = 65536;

  // Field widths fixed by the interface
  localparam int FRAME_W   = 16;
  localparam int WSIZE_W   = 6;
  localparam int TOTAL_W   = 17;
  localparam int DCOUNT_W  = 17;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 17;

  // Internal widths
  localparam int WIN_W = $clog2(WINDOW_MAX + 1);
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAMES = 1'b1;

  // Register reset values
  localparam logic [WSIZE_W-1:0] WINDOW_RST = 6'd4;
  localparam logic [TOTAL_W-1:0] TOTAL_RST  = 17'd16;

  typedef struct packed {
    logic action;
    logic frame_lost;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0]  frame_number;
    logic                was_lost;
    logic                round_end;
    logic [DCOUNT_W-1:0] delivered_count;
    logic                transfer_done;
  } out_item_t;

  // Requests to the window chain
  typedef struct packed {
    logic clear;
    logic pop;
    logic push;
  } chain_ctl_t;

  // Per-cell controls
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/srsw_cell.sv */
// ----------------------------------------------------------------------------
// srsw_cell
// One window slot: loads a new frame number or takes its neighbour's.
// ----------------------------------------------------------------------------
`default_nettype none

module srsw_cell
  import srsw_pkg::*;
(
  input  wire                clk,
  input  cell_ctl_t          ctl,
  input  wire [FRAME_W-1:0]  nbr_data,
  input  wire [FRAME_W-1:0]  wr_data,
  output logic [FRAME_W-1:0] q
);

  logic [FRAME_W-1:0] data_r;
  logic [FRAME_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.load) begin
      data_nxt = wr_data;
    end else if (ctl.shift) begin
      data_nxt = nbr_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

`default_nettype wire

/* hw/rtl/srsw_chain.sv */
// ----------------------------------------------------------------------------
// srsw_chain
// Row of window cells kept as an in-order queue: the head leaves on a pop,
// every cell takes its neighbour's frame, and a push lands at the tail.
// ----------------------------------------------------------------------------
`default_nettype none

module srsw_chain
  import srsw_pkg::*;
(
  input  wire                clk,
  input  wire                rst_n,
  input  chain_ctl_t         ctl,
  input  wire [FRAME_W-1:0]  wr_data,
  output logic [FRAME_W-1:0] head_data
);

  logic [WIN_W-1:0]   cnt_r;
  logic [WIN_W-1:0]   cnt_nxt;
  logic [WIN_W-1:0]   tail;
  logic [FRAME_W-1:0] cell_q [WINDOW_MAX];

  // Tail slot after this cycle's pop
  assign tail = ctl.pop ? (cnt_r - WIN_W'(1)) : cnt_r;

  always_comb begin
    cnt_nxt = cnt_r - WIN_W'(ctl.pop) + WIN_W'(ctl.push);
    if (ctl.clear) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    cell_ctl_t          c_ctl;
    logic [FRAME_W-1:0] nbr;

    if (i == WINDOW_MAX - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end

    assign c_ctl.shift = ctl.pop;
    assign c_ctl.load  = ctl.push && !ctl.clear && (tail == WIN_W'(i));

    srsw_cell u_cell (
      .clk      (clk),
      .ctl      (c_ctl),
      .nbr_data (nbr),
      .wr_data  (wr_data),
      .q        (cell_q[i])
    );
  end

  assign head_data = cell_q[0];

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= WIN_W'(WINDOW_MAX))
    else $error("window chain over-full");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> cnt_r != '0)
    else $error("pop from empty window chain");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.push && !ctl.pop && !ctl.clear) |-> cnt_r < WIN_W'(WINDOW_MAX))
    else $error("push into full window chain");

endmodule

`default_nettype wire

/* hw/rtl/selective_repeat_sender_window.sv */
// A result is registered onto out_*, or into the skid entry while out_* still waits.
// Throughput: one request per cycle; a two-entry output buffer takes a new
//   request while an earlier result still waits, and in_ready falls only when
//   both entries are full.
// Reset: synchronous; registers return to window 4 and 16 frames and a fresh
//   transfer starts at once; window cells are not cleared.
// ----------------------------------------------------------------------------
// selective_repeat_sender_window
// Sender window of a selective-repeat ARQ transfer: frame numbering, round
// bookkeeping and compaction of lost frames into the next round.
// ----------------------------------------------------------------------------
`default_nettype none

module selective_repeat_sender_window
  import srsw_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output out_item_t            out_data,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DAT_W-1:0]  cfg_wdata
);

  // Configuration
  logic [WSIZE_W-1:0] reg_window_r;
  logic [TOTAL_W-1:0] reg_total_r;

  // Transfer state
  logic [WIN_W-1:0] act_window_r, act_window_nxt;
  logic [CNT_W-1:0] act_total_r,  act_total_nxt;
  logic [WIN_W-1:0] slot_r,       slot_nxt;
  logic [WIN_W-1:0] lost_r,       lost_nxt;
  logic [WIN_W-1:0] kept_r,       kept_nxt;
  logic [WIN_W-1:0] round_len_r,  round_len_nxt;
  logic [CNT_W-1:0] fresh_r,      fresh_nxt;
  logic [CNT_W-1:0] delivered_r,  delivered_nxt;

  // Output buffer
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      skid_valid_r;
  out_item_t skid_data_r;

  logic               in_fire;
  logic               out_fire;
  logic               restart;
  logic               active;
  logic               step;
  logic               rend;
  logic [WIN_W-1:0]   win_clamp;
  logic [CNT_W-1:0]   tot_clamp;
  logic [WIN_W-1:0]   slot_inc;
  logic [CNT_W-1:0]   deliv_step;
  logic [CNT_W-1:0]   remaining;
  logic [FRAME_W-1:0] frame;
  logic [FRAME_W-1:0] head_data;
  chain_ctl_t         chain_ctl;
  out_item_t          res;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_window_r <= WINDOW_RST;
      reg_total_r  <= TOTAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_SIZE:  reg_window_r <= cfg_wdata[WSIZE_W-1:0];
        CFG_TOTAL_FRAMES: reg_total_r  <= cfg_wdata[TOTAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Window of zero counts as one; clip both to what the hardware holds
  always_comb begin
    if (reg_window_r == '0) begin
      win_clamp = WIN_W'(1);
    end else if (int'(reg_window_r) > WINDOW_MAX) begin
      win_clamp = WIN_W'(WINDOW_MAX);
    end else begin
      win_clamp = WIN_W'(reg_window_r);
    end
    if (int'(reg_total_r) > MAX_FRAMES) begin
      tot_clamp = CNT_W'(MAX_FRAMES);
    end else begin
      tot_clamp = CNT_W'(reg_total_r);
    end
  end

  assign restart  = in_data.action;
  assign active   = delivered_r < act_total_r;
  assign step     = in_fire && !restart && active;
  assign slot_inc = slot_r + WIN_W'(1);
  assign rend     = step && (slot_inc >= round_len_r);

  assign chain_ctl.clear = in_fire && restart;
  assign chain_ctl.pop   = step && (slot_r < kept_r);
  assign chain_ctl.push  = step && in_data.frame_lost;

  assign frame = chain_ctl.pop ? head_data : FRAME_W'(fresh_r);

  assign deliv_step = delivered_r + CNT_W'(step && !in_data.frame_lost);
  assign remaining  = act_total_r - deliv_step;

  always_comb begin
    act_window_nxt = act_window_r;
    act_total_nxt  = act_total_r;
    slot_nxt       = slot_r;
    lost_nxt       = lost_r;
    kept_nxt       = kept_r;
    round_len_nxt  = round_len_r;
    fresh_nxt      = fresh_r;
    delivered_nxt  = delivered_r;
    res            = '0;

    if (in_fire && restart) begin
      act_window_nxt = win_clamp;
      act_total_nxt  = tot_clamp;
      slot_nxt       = '0;
      lost_nxt       = '0;
      kept_nxt       = '0;
      fresh_nxt      = '0;
      delivered_nxt  = '0;
      round_len_nxt  = (int'(tot_clamp) < int'(win_clamp)) ? WIN_W'(tot_clamp) : win_clamp;
      res.transfer_done = (tot_clamp == '0);
    end else if (step) begin
      if (!chain_ctl.pop) begin
        fresh_nxt = fresh_r + CNT_W'(1);
      end
      lost_nxt      = lost_r + WIN_W'(in_data.frame_lost);
      delivered_nxt = deliv_step;
      slot_nxt      = slot_inc;
      // Close the round: lost frames become next round's head
      if (rend) begin
        kept_nxt      = lost_nxt;
        lost_nxt      = '0;
        slot_nxt      = '0;
        round_len_nxt = (int'(remaining) < int'(act_window_r)) ? WIN_W'(remaining)
                                                               : act_window_r;
      end
      res.frame_number    = frame;
      res.was_lost        = in_data.frame_lost;
      res.round_end       = rend;
      res.delivered_count = DCOUNT_W'(deliv_step);
      res.transfer_done   = deliv_step >= act_total_r;
    end else begin
      res.delivered_count = DCOUNT_W'(delivered_r);
      res.transfer_done   = !active;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_window_r <= WIN_W'(WINDOW_RST);
      act_total_r  <= CNT_W'(TOTAL_RST);
      slot_r       <= '0;
      lost_r       <= '0;
      kept_r       <= '0;
      round_len_r  <= (int'(TOTAL_RST) < int'(WINDOW_RST)) ? WIN_W'(TOTAL_RST)
                                                            : WIN_W'(WINDOW_RST);
      fresh_r      <= '0;
      delivered_r  <= '0;
    end else begin
      act_window_r <= act_window_nxt;
      act_total_r  <= act_total_nxt;
      slot_r       <= slot_nxt;
      lost_r       <= lost_nxt;
      kept_r       <= kept_nxt;
      round_len_r  <= round_len_nxt;
      fresh_r      <= fresh_nxt;
      delivered_r  <= delivered_nxt;
    end
  end

  srsw_chain u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (chain_ctl),
    .wr_data   (frame),
    .head_data (head_data)
  );

  // Two-entry output buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_data_r <= skid_data_r;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_data_r <= res;
      end else begin
        skid_data_r <= res;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_slot_in_round: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r == '0 || slot_r < round_len_r)
    else $error("slot position beyond round length");

  a_deliv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    delivered_r <= act_total_r)
    else $error("delivered count beyond transfer total");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && skid_valid_r))
    else $error("input stalled with output buffer not full");

endmodule

`default_nettype wire
